/* rtl/core/min_distance_corner_selector_unit_macros.svh */
// Assertion helpers for the corner selector checker
`ifndef MIN_DISTANCE_CORNER_SELECTOR_UNIT_MACROS_SVH
`define MIN_DISTANCE_CORNER_SELECTOR_UNIT_MACROS_SVH

// Check a property at each rising edge outside reset
`define MDCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at each rising edge, reset included
`define MDCS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/mdcs_pkg.sv */
package mdcs_pkg;

  // Store and image geometry
  localparam int MAX_POINTS = 256;
  localparam int IMG_WIDTH  = 640;
  localparam int IMG_HEIGHT = 512;

  // Field widths
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int DIST_W  = 8;
  localparam int KEEP_W  = 9;
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int LIM_W   = 2 * DIST_W;
  localparam int SQX_W   = 2 * X_W;
  localparam int SQY_W   = 2 * Y_W;
  localparam int SUM_W   = SQX_W + 1;
  localparam int PT_W    = X_W + Y_W;

  // Stream and configuration port widths
  localparam int S_DATA_W = 24;
  localparam int M_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEP_DIST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_KEEP = 1'd1;

  // Register reset values
  localparam logic [DIST_W-1:0] SEP_DIST_RST = 8'd30;
  localparam logic [KEEP_W-1:0] MAX_KEEP_RST = 9'd150;

endpackage

/* rtl/core/mdcs_ram.sv */
module mdcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/min_distance_corner_selector_unit.sv */
// Channel  Direction  Payload
// s_*      in         tdata: cand_x, cand_y; tlast: last_candidate
// m_*      out        tdata: out_x, out_y, kept_total; tuser: accepted; tlast: frame_done
// cfg_*    in         index 0: separation distance, index 1: keep limit
//
// One item at a time: when its distance is checked, the stored points are read from the
// point memory one per cycle, then pass a square stage and a compare stage before the
// result state; an item rejected by the limit, with suppression off or with an empty store
// goes straight to the result state.
// Reset is synchronous; it empties the store and restores the register defaults.
// A stalled output holds its item; the next input item is taken meanwhile and waits
// in the result state until the output register frees up.
module min_distance_corner_selector_unit import mdcs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // [9:0] cand_x, [18:10] cand_y, rest zero
  input  logic                  s_tlast,   // last_candidate
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // [9:0] out_x, [18:10] out_y, [27:19] kept_total
  output logic                  m_tuser,   // [0] accepted
  output logic                  m_tlast,   // frame_done
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0]        state;
  logic [DIST_W-1:0] sep_dist;
  logic [KEEP_W-1:0] max_keep;
  logic [CNT_W-1:0]  kept_count;
  logic [X_W-1:0]    cand_x;
  logic [Y_W-1:0]    cand_y;
  logic              cand_last;
  logic [LIM_W-1:0]  lim;
  logic [CNT_W-1:0]  rd_ptr;
  logic              rd_vld;
  logic              sq_vld;
  logic [SQX_W-1:0]  sq_x;
  logic [SQY_W-1:0]  sq_y;
  logic              hit;
  logic              ok;

  logic              in_acc;
  logic              limited;
  logic              issue;
  logic              out_free;
  logic              finish;
  logic [PT_W-1:0]   rd_pt;
  logic [X_W-1:0]    kx;
  logic [Y_W-1:0]    ky;
  logic [X_W-1:0]    ax;
  logic [Y_W-1:0]    ay;
  logic [SUM_W-1:0]  dist_sq;
  logic [CNT_W-1:0]  kept_total;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;

  // Reject without distance check once a limit is reached
  assign limited = ((max_keep != '0) && (CNT_W'(max_keep) <= kept_count)) ||
                   (kept_count >= CNT_W'(MAX_POINTS));

  assign issue    = (state == ST_SCAN) && (rd_ptr < kept_count);
  assign out_free = !m_tvalid || m_tready;
  assign finish   = (state == ST_RESULT) && out_free;

  // Point memory: one read per scan cycle, one write per kept candidate
  mdcs_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_pts (
    .clk     (clk),
    .wr_en   (finish && ok),
    .wr_addr (kept_count[ADDR_W-1:0]),
    .wr_data ({cand_y, cand_x}),
    .rd_en   (issue),
    .rd_addr (rd_ptr[ADDR_W-1:0]),
    .rd_data (rd_pt)
  );

  // Absolute offsets to the stored point
  assign kx = rd_pt[X_W-1:0];
  assign ky = rd_pt[PT_W-1:X_W];
  assign ax = (cand_x >= kx) ? (cand_x - kx) : (kx - cand_x);
  assign ay = (cand_y >= ky) ? (cand_y - ky) : (ky - cand_y);

  assign dist_sq    = SUM_W'(sq_x) + SUM_W'(sq_y);
  assign kept_total = kept_count + CNT_W'(ok);

  // Square the offsets; the sequencer compares their sum against the limit
  always_ff @(posedge clk) begin
    sq_x <= SQX_W'(ax) * SQX_W'(ax);
    sq_y <= SQY_W'(ay) * SQY_W'(ay);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sep_dist <= SEP_DIST_RST;
      max_keep <= MAX_KEEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SEP_DIST: sep_dist <= cfg_data[DIST_W-1:0];
        REG_MAX_KEEP: max_keep <= cfg_data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Latch candidate payload and the squared separation limit on accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cand_x    <= s_tdata[X_W-1:0];
      cand_y    <= s_tdata[PT_W-1:X_W];
      cand_last <= s_tlast;
      lim       <= LIM_W'(sep_dist) * LIM_W'(sep_dist);
    end
  end

  // Sequencer: accept, scan the store, deliver the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      kept_count <= '0;
      rd_ptr     <= '0;
      rd_vld     <= 1'b0;
      sq_vld     <= 1'b0;
      hit        <= 1'b0;
      ok         <= 1'b0;
    end else begin
      rd_vld <= issue;
      sq_vld <= rd_vld;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            rd_ptr <= '0;
            hit    <= 1'b0;
            if (limited) begin
              ok    <= 1'b0;
              state <= ST_RESULT;
            end else if ((sep_dist == '0) || (kept_count == '0)) begin
              ok    <= 1'b1;
              state <= ST_RESULT;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (sq_vld && (dist_sq < SUM_W'(lim))) begin
            hit <= 1'b1;
          end
          if (!issue && !rd_vld && !sq_vld) begin
            ok    <= !hit;
            state <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            kept_count <= cand_last ? '0 : kept_total;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {{(M_DATA_W - PT_W - KEEP_W){1'b0}}, kept_total[KEEP_W-1:0], cand_y, cand_x};
      m_tuser <= ok;
      m_tlast <= cand_last;
    end
  end

endmodule

/* rtl/core/mdcs_checker.sv */
`include "min_distance_corner_selector_unit_macros.svh"

module mdcs_checker import mdcs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [M_DATA_W-1:0]   m_tdata,
  input logic                  m_tuser,
  input logic                  m_tlast
);

  // Hold a stalled output item
  `MDCS_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output item changed while stalled")

  // Empty the output after reset
  `MDCS_ASSERT_RST(a_rst_out, rst |=> !m_tvalid, "output valid right after reset")

  // A kept candidate is counted
  `MDCS_ASSERT(a_kept_count, m_tvalid && m_tuser |-> m_tdata[PT_W+KEEP_W-1:PT_W] != '0, "accepted item with zero count")

  // Work on one item at a time
  `MDCS_ASSERT(a_one_item, s_tvalid && s_tready |=> !s_tready, "input taken on consecutive cycles")

endmodule

bind min_distance_corner_selector_unit mdcs_checker u_mdcs_checker (.*);
